// ===== src/cdq_pkg.sv =====
`default_nettype none
package cdq_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int WORD_W          = 32;
  localparam int CAP_W           = 7;
  localparam int STATUS_W        = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic en;   // legal operation this cycle
    logic clr;  // empty the deque
    cmd_t cmd;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/cdq_cell.sv =====
`default_nettype none
module cdq_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  cdq_pkg::cell_ctrl_t          ctrl,
  input  wire [cdq_pkg::WORD_W-1:0]    push_value,
  input  wire [cdq_pkg::WORD_W-1:0]    left_data,
  input  wire                          left_valid,
  input  wire [cdq_pkg::WORD_W-1:0]    right_data,
  input  wire                          right_valid,
  output logic [cdq_pkg::WORD_W-1:0]   data_o,
  output logic                         valid_o,
  output logic [cdq_pkg::WORD_W-1:0]   rear_data_o
);
  import cdq_pkg::*;

  logic [WORD_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;
  logic              is_rear;

  assign is_rear = valid_r & ~right_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.en) begin
      unique case (ctrl.cmd)
        CMD_PUSH_FRONT: begin
          data_nxt  = left_data;
          valid_nxt = left_valid;
        end
        CMD_PUSH_REAR: begin
          if (!valid_r && left_valid) begin
            data_nxt  = push_value;
            valid_nxt = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          data_nxt  = right_data;
          valid_nxt = right_valid;
        end
        CMD_POP_REAR: begin
          if (is_rear) valid_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data_o      = data_r;
  assign valid_o     = valid_r;
  assign rear_data_o = is_rear ? data_r : '0;

endmodule
`default_nettype wire

// ===== src/circular_deque_core.sv =====
`default_nettype none
// Double-ended queue of signed words held in a row of shift cells.
// One result per accepted command, strobed in the cycle after the transfer.
// Throughput: one command per cycle while busy is low; each cell updates from its neighbors in one step.
// Reset (synchronous, rst_n low): deque empty, capacity 64; busy stays high during reset
// and clears at the first clock edge that samples rst_n high.
// Results cannot be stalled; the receiver must take each strobe as it comes.
module circular_deque_core #(
  parameter int STORE_DEPTH = cdq_pkg::STORE_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // command channel
  input  wire                                 start,
  output logic                                busy,
  input  wire [1:0]                           in_cmd,
  input  wire signed [cdq_pkg::WORD_W-1:0]    in_push_value,
  // result channel
  output logic                                out_strobe,
  output logic [cdq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [cdq_pkg::WORD_W-1:0]   out_popped_value,
  output logic [cdq_pkg::CAP_W-1:0]           out_fill_count,
  // capacity register write
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [cdq_pkg::CAP_W-1:0]            cfg_data
);
  import cdq_pkg::*;

  // count holds 0..STORE_DEPTH; compare width covers the 7-bit register too
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  logic              busy_r;
  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     count_r, count_nxt;

  logic              out_strobe_r;
  status_t           out_status_r, status_nxt;
  logic [WORD_W-1:0] out_popped_r, popped_nxt;
  logic [CAP_W-1:0]  out_fill_r;

  logic              take;
  logic              cfg_take;
  cmd_t              cmd;
  logic [MW-1:0]     cap_eff;
  logic              full, empty, legal;
  cell_ctrl_t        ctrl;

  // cell row: cell 0 is the front of the deque, entries packed toward it
  logic [WORD_W-1:0] cell_data  [STORE_DEPTH];
  logic              cell_valid [STORE_DEPTH];
  logic [WORD_W-1:0] cell_rear  [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_vec;
  logic [WORD_W-1:0] rear_word;

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign take      = start & ~busy_r;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign cmd       = cmd_t'(in_cmd);

  // capacity 0 acts as 1, anything past the cell count acts as the cell count
  always_comb begin
    cap_eff = MW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = MW'(1);
    end else if (MW'(cap_r) > MW'(STORE_DEPTH)) begin
      cap_eff = MW'(STORE_DEPTH);
    end
  end

  assign full  = MW'(count_r) >= cap_eff;
  assign empty = (count_r == '0);

  // status and legality of the command on the port
  always_comb begin
    legal      = 1'b0;
    status_nxt = ST_DONE;
    unique case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        legal      = ~full;
        status_nxt = full ? ST_OVERFLOW : ST_DONE;
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        legal      = ~empty;
        status_nxt = empty ? ST_UNDERFLOW : ST_DONE;
      end
      default: ;
    endcase
  end

  assign ctrl.en  = take & legal & ~cfg_take;
  assign ctrl.clr = cfg_take;
  assign ctrl.cmd = cmd;

  genvar gi;
  generate
    for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
      logic [WORD_W-1:0] l_data, r_data;
      logic              l_valid, r_valid;
      if (gi == 0) begin : g_front
        // push-front value enters here; always "left valid" for rear fills
        assign l_data  = in_push_value;
        assign l_valid = 1'b1;
      end else begin : g_inner_l
        assign l_data  = cell_data[gi-1];
        assign l_valid = cell_valid[gi-1];
      end
      if (gi == STORE_DEPTH - 1) begin : g_back
        assign r_data  = '0;
        assign r_valid = 1'b0;
      end else begin : g_inner_r
        assign r_data  = cell_data[gi+1];
        assign r_valid = cell_valid[gi+1];
      end
      cdq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .push_value  (in_push_value),
        .left_data   (l_data),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_valid (r_valid),
        .data_o      (cell_data[gi]),
        .valid_o     (cell_valid[gi]),
        .rear_data_o (cell_rear[gi])
      );
      assign valid_vec[gi] = cell_valid[gi];
    end
  endgenerate

  // at most one cell flags itself as rear, so an OR picks its word
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      rear_word = rear_word | cell_rear[i];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    if (cfg_take) begin
      count_nxt = '0;
    end else if (ctrl.en) begin
      unique case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: count_nxt = count_r + CW'(1);
        CMD_POP_FRONT: begin
          count_nxt  = count_r - CW'(1);
          popped_nxt = cell_data[0];
        end
        CMD_POP_REAR: begin
          count_nxt  = count_r - CW'(1);
          popped_nxt = rear_word;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // result payload, no reset needed
    out_status_r <= status_nxt;
    out_popped_r <= popped_nxt;
    out_fill_r   <= CAP_W'(count_nxt);
    if (!rst_n) begin
      busy_r       <= 1'b1;
      cap_r        <= CAP_RESET;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      if (cfg_take) cap_r <= cfg_data;
      count_r      <= count_nxt;
      out_strobe_r <= take;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_fill_count   = out_fill_r;

  // every accepted command yields a strobe on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("accepted command without result strobe");

  // occupied cells match the entry count, which stays within the cell count
  a_cells_track_count: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_vec) == count_r) && (count_r <= CW'(STORE_DEPTH)))
    else $error("cell occupancy disagrees with entry count");

  // an overflow or underflow leaves the fill count unchanged and pops a zero value
  a_reject_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_take && !legal) |=> ($stable(count_r) && out_popped_value == '0))
    else $error("rejected command changed the deque");

endmodule
`default_nettype wire

// ===== sim/tb_circular_deque_core.sv =====
`timescale 1ns / 100ps

module tb_circular_deque_core;
  import cdq_pkg::*;

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 300000;

  // one expected result of the deque
  typedef struct {
    status_t            status;
    logic signed [31:0] popped;
    logic [6:0]         fill;
  } deque_result_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic [1:0]         in_cmd        = CMD_PUSH_FRONT;
  logic signed [31:0] in_push_value = '0;
  logic               cfg_valid     = 1'b0;
  logic [6:0]         cfg_data      = '0;
  wire                busy;
  wire                out_strobe;
  wire [1:0]          out_status;
  wire signed [31:0]  out_popped_value;
  wire [6:0]          out_fill_count;
  wire                cfg_ready;

  circular_deque_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_push_value    (in_push_value),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_fill_count   (out_fill_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow deque: own copy of the store, pointers, count and capacity register.
  // ---------------------------------------------------------------------------
  logic [31:0]   shadow_slots [SLOTS];
  int unsigned   front_slot;
  int unsigned   rear_slot;     // slot just past the rear entry
  int unsigned   held_count;
  logic [6:0]    capacity_reg = CAP_RESET;

  deque_result_t pending_results [$];

  int            error_count;
  int            transfer_count;
  int            capacity_writes;
  int            overflow_count;
  int            underflow_count;
  int            pop_count;
  int            cycle_count;

  // 0 behaves as 1, anything past the store depth as the full store
  function automatic int unsigned usable_slots(logic [6:0] reg_value);
    if (reg_value == 0) return 1;
    if (reg_value > SLOTS) return SLOTS;
    return reg_value;
  endfunction

  function automatic int unsigned step_up(int unsigned i, int unsigned lim);
    return (i + 1 >= lim) ? 0 : i + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned i, int unsigned lim);
    return (i == 0 || i >= lim) ? lim - 1 : i - 1;
  endfunction

  // A capacity write always empties the deque; stored words stay but are dead.
  task automatic load_capacity(input logic [6:0] value);
    capacity_reg = value;
    front_slot   = 0;
    rear_slot    = 0;
    held_count   = 0;
  endtask

  task automatic apply_deque_op(input cmd_t op, input logic [31:0] word,
                                output deque_result_t r);
    int unsigned lim;
    lim = usable_slots(capacity_reg);
    if (front_slot >= lim) front_slot = 0;
    if (rear_slot >= lim) rear_slot = 0;
    r.status = ST_DONE;
    r.popped = '0;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (held_count >= lim) begin
          r.status = ST_OVERFLOW;
        end else if (op == CMD_PUSH_FRONT) begin
          front_slot = step_down(front_slot, lim);
          shadow_slots[front_slot] = word;
          held_count++;
        end else begin
          shadow_slots[rear_slot] = word;
          rear_slot = step_up(rear_slot, lim);
          held_count++;
        end
      end
      default: begin
        if (held_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (op == CMD_POP_FRONT) begin
          r.popped   = shadow_slots[front_slot];
          front_slot = step_up(front_slot, lim);
          held_count--;
        end else begin
          rear_slot = step_down(rear_slot, lim);
          r.popped  = shadow_slots[rear_slot];
          held_count--;
        end
      end
    endcase
    r.fill = held_count[6:0];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: all sampling happens here, at the rising edge, before any of the
  // testbench's nonblocking drives land. Results are checked before the
  // command taken at the same edge is predicted, so a stray result can never
  // be matched against an expectation created in that very step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending (status)", out_status, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_popped_value !== want.popped)
            report_mismatch("popped_value", out_popped_value, want.popped);
          if (out_fill_count !== want.fill)
            report_mismatch("fill_count", out_fill_count, want.fill);
        end
      end
      if (cfg_valid && cfg_ready) begin
        load_capacity(cfg_data);
        capacity_writes++;
      end
      if (start && !busy) begin
        apply_deque_op(cmd_t'(in_cmd), in_push_value, want);
        pending_results.push_back(want);
        transfer_count++;
        if (want.status == ST_OVERFLOW) overflow_count++;
        if (want.status == ST_UNDERFLOW) underflow_count++;
        if (want.status == ST_DONE && in_cmd[1]) pop_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left just after a rising edge.
  // start is left high after a transfer so back-to-back commands never see
  // a low/high pair in one step; whoever pauses lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_op(input cmd_t op, input logic [31:0] word, input int idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= op;
    in_push_value <= word;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every pending result is back; wait for a clock edge first so a
  // transfer taken at the current edge is already in the queue.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_t pick_op(input int push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    return $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
  endfunction

  // mostly full-range words, some sign/zero extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset capacity: both pops on empty, extreme words through both ends,
  // then one entry left behind for the capacity test to discard.
  task automatic test_empty_and_extremes();
    send_op(CMD_POP_FRONT,  32'h0, 0);
    send_op(CMD_POP_REAR,   32'h0, 0);
    send_op(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 0);
    send_op(CMD_PUSH_REAR,  32'h8000_0000, 0);
    send_op(CMD_PUSH_FRONT, 32'h0000_0000, 0);
    send_op(CMD_PUSH_REAR,  32'hFFFF_FFFF, 0);
    send_op(CMD_POP_REAR,   32'h0, 0);
    send_op(CMD_POP_FRONT,  32'h0, 0);
    send_op(CMD_POP_FRONT,  32'h0, 0);
    send_op(CMD_POP_REAR,   32'h0, 0);
    send_op(CMD_POP_FRONT,  32'h0, 0);
    send_op(CMD_PUSH_REAR,  32'h5A5A_A5A5, 0);
  endtask

  // Smallest capacities: a write empties a non-empty deque, one-slot
  // overflow, two-slot wrap of the front pointer.
  task automatic test_capacity_edges();
    set_capacity(7'd1);
    send_op(CMD_POP_REAR,   32'h0, 0);
    send_op(CMD_PUSH_FRONT, 32'h1234_5678, 0);
    send_op(CMD_PUSH_REAR,  32'hDEAD_BEEF, 0);
    send_op(CMD_POP_REAR,   32'h0, 0);
    send_op(CMD_PUSH_REAR,  32'hC3C3_3C3C, 0);
    send_op(CMD_POP_FRONT,  32'h0, 0);
    set_capacity(7'd2);
    send_op(CMD_PUSH_REAR,  32'h0000_0001, 0);
    send_op(CMD_PUSH_FRONT, 32'hFFFF_FFFE, 0);
    send_op(CMD_PUSH_FRONT, 32'h0F0F_0F0F, 0);
    send_op(CMD_POP_FRONT,  32'h0, 0);
    send_op(CMD_POP_FRONT,  32'h0, 0);
    send_op(CMD_POP_REAR,   32'h0, 0);
  endtask

  // Bursts with a random push bias so the deque swings between empty and
  // full; halfway through the sender holds off until all results are in.
  task automatic run_random_phase(input int idle_pct, input logic [6:0] cap,
                                  input int n_ops);
    int burst_left;
    int push_pct;
    burst_left = 0;
    push_pct   = 50;
    set_capacity(cap);
    for (int k = 0; k < n_ops; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(80, 8);
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      burst_left--;
      send_op(pick_op(push_pct), pick_word(), idle_pct);
      if (k == n_ops / 2) drain_results();
    end
    drain_results();
  endtask

  task automatic test_random_light_sender_gaps();
    run_random_phase(23, 7'd3, 120);
    run_random_phase(23, 7'd64, 130);
    run_random_phase(23, 7'd0, 40);
  endtask

  task automatic test_random_heavy_sender_gaps();
    run_random_phase(88, 7'd2, 100);
    run_random_phase(88, 7'd5, 110);
    run_random_phase(88, 7'd127, 100);
  endtask

  task automatic test_random_back_to_back();
    run_random_phase(0, 7'd1, 60);
    run_random_phase(0, 7'd7, 120);
    run_random_phase(0, 7'd64, 150);
    run_random_phase(0, 7'($urandom_range(64, 1)), 70);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_extremes();
    test_capacity_edges();
    test_random_light_sender_gaps();
    test_random_heavy_sender_gaps();
    test_random_back_to_back();

    // everything is drained by the last phase; keep watching for any stray
    // strobe before the report
    drain_results();
    repeat (4) @(posedge clk);

    $display("covered %0d commands over %0d capacity writes (0, 1, 2 ... 64, 127)",
             transfer_count, capacity_writes);
    $display("%0d overflows, %0d underflows, %0d good pops, %0d mismatches",
             overflow_count, underflow_count, pop_count, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
